>>> rtl/pimq_pkg.sv
// Package for the piezo impact qualifier: field widths, register map,
// configuration and item types shared by all rtl/ files. No dependencies.
package pimq_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  // Default time width
  localparam int unsigned TIME_BITS_DEFAULT = 32;

  // Saturation value of the edge total
  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] HIT_THR_RST     = 12'd1200;
  localparam logic [SAMPLE_W-1:0] REARM_THR_RST   = 12'd400;
  localparam logic [MS_W-1:0]     WINDOW_RST      = 16'd20;
  localparam logic [EDGE_W-1:0]   MIN_EDGES_RST   = 16'd1;
  localparam logic [MS_W-1:0]     COOLDOWN_RST    = 16'd250;
  localparam logic [MS_W-1:0]     REARM_CHECK_RST = 16'd10;
  localparam logic [MS_W-1:0]     REARM_STAB_RST  = 16'd80;
  localparam logic [MODE_W-1:0]   MODE_RST        = 2'd3;

  // Register map, word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_HIT_THR     = 3'd0,
    REG_REARM_THR   = 3'd1,
    REG_WINDOW      = 3'd2,
    REG_MIN_EDGES   = 3'd3,
    REG_COOLDOWN    = 3'd4,
    REG_REARM_CHECK = 3'd5,
    REG_REARM_STAB  = 3'd6,
    REG_MODE        = 3'd7
  } reg_idx_e;

  // Sensor mode bits
  localparam int unsigned MODE_ANALOG_BIT  = 0;
  localparam int unsigned MODE_DIGITAL_BIT = 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] hit_thr;
    logic [SAMPLE_W-1:0] rearm_thr;
    logic [MS_W-1:0]     window_ms;
    logic [EDGE_W-1:0]   min_edges;
    logic [MS_W-1:0]     lockout_ms;
    logic [MS_W-1:0]     rearm_check_ms;
    logic [MS_W-1:0]     quiet_hold_ms;
    logic [MODE_W-1:0]   sensor_mode;
  } cfg_t;

  // Input item without its time field
  typedef struct packed {
    logic [SAMPLE_W-1:0] analog_sample;
    logic [EDGE_W-1:0]   edge_count;
    logic                comparator_level;
    logic                blocked;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                hit;
    logic [SAMPLE_W-1:0] hit_peak;
    logic [EDGE_W-1:0]   hit_edges;
    logic                is_armed;
    logic                capturing;
    logic                locked_out;
  } res_item_t;

endpackage

>>> rtl/pimq_cfg.sv
// Configuration register file of the piezo impact qualifier, APB-style port.
// Depends on pimq_pkg.
module pimq_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pimq_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pimq_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pimq_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output pimq_pkg::cfg_t                     cfg_o
);

  pimq_pkg::cfg_t   cfg_q;
  pimq_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = pimq_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_thr         <= pimq_pkg::HIT_THR_RST;
      cfg_q.rearm_thr       <= pimq_pkg::REARM_THR_RST;
      cfg_q.window_ms       <= pimq_pkg::WINDOW_RST;
      cfg_q.min_edges       <= pimq_pkg::MIN_EDGES_RST;
      cfg_q.lockout_ms      <= pimq_pkg::COOLDOWN_RST;
      cfg_q.rearm_check_ms  <= pimq_pkg::REARM_CHECK_RST;
      cfg_q.quiet_hold_ms   <= pimq_pkg::REARM_STAB_RST;
      cfg_q.sensor_mode     <= pimq_pkg::MODE_RST;
    end else if (wr_en) begin
      case (idx)
        pimq_pkg::REG_HIT_THR:     cfg_q.hit_thr         <= pwdata[pimq_pkg::SAMPLE_W-1:0];
        pimq_pkg::REG_REARM_THR:   cfg_q.rearm_thr       <= pwdata[pimq_pkg::SAMPLE_W-1:0];
        pimq_pkg::REG_WINDOW:      cfg_q.window_ms       <= pwdata[pimq_pkg::MS_W-1:0];
        pimq_pkg::REG_MIN_EDGES:   cfg_q.min_edges       <= pwdata[pimq_pkg::EDGE_W-1:0];
        pimq_pkg::REG_COOLDOWN:    cfg_q.lockout_ms      <= pwdata[pimq_pkg::MS_W-1:0];
        pimq_pkg::REG_REARM_CHECK: cfg_q.rearm_check_ms  <= pwdata[pimq_pkg::MS_W-1:0];
        pimq_pkg::REG_REARM_STAB:  cfg_q.quiet_hold_ms   <= pwdata[pimq_pkg::MS_W-1:0];
        pimq_pkg::REG_MODE:        cfg_q.sensor_mode     <= pwdata[pimq_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    case (idx)
      pimq_pkg::REG_HIT_THR:     prdata = pimq_pkg::CFG_DATA_W'(cfg_q.hit_thr);
      pimq_pkg::REG_REARM_THR:   prdata = pimq_pkg::CFG_DATA_W'(cfg_q.rearm_thr);
      pimq_pkg::REG_WINDOW:      prdata = pimq_pkg::CFG_DATA_W'(cfg_q.window_ms);
      pimq_pkg::REG_MIN_EDGES:   prdata = pimq_pkg::CFG_DATA_W'(cfg_q.min_edges);
      pimq_pkg::REG_COOLDOWN:    prdata = pimq_pkg::CFG_DATA_W'(cfg_q.lockout_ms);
      pimq_pkg::REG_REARM_CHECK: prdata = pimq_pkg::CFG_DATA_W'(cfg_q.rearm_check_ms);
      pimq_pkg::REG_REARM_STAB:  prdata = pimq_pkg::CFG_DATA_W'(cfg_q.quiet_hold_ms);
      pimq_pkg::REG_MODE:        prdata = pimq_pkg::CFG_DATA_W'(cfg_q.sensor_mode);
      default:                   prdata = '0;
    endcase
  end

endmodule

>>> rtl/pimq_core.sv
// Qualifier state and per-tick decision logic: capture window, hit decision,
// lockout and re-arm checks. Depends on pimq_pkg.
module pimq_core #(
  parameter int unsigned TIME_BITS = pimq_pkg::TIME_BITS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  pimq_pkg::cfg_t       cfg_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  pimq_pkg::in_item_t   item_i,
  output pimq_pkg::res_item_t  res_o
);

  localparam int unsigned SW = pimq_pkg::SAMPLE_W;
  localparam int unsigned EW = pimq_pkg::EDGE_W;

  // State
  logic                 open_q,      open_d;
  logic [TIME_BITS-1:0] start_q,     start_d;
  logic [SW-1:0]        peak_q,      peak_d;
  logic [EW-1:0]        total_q,     total_d;
  logic                 by_edges_q,  by_edges_d;
  logic                 armed_q,     armed_d;
  logic                 qvalid_q,    qvalid_d;
  logic [TIME_BITS-1:0] qsince_q,    qsince_d;
  logic [TIME_BITS-1:0] lastchk_q,   lastchk_d;
  logic [TIME_BITS-1:0] lockend_q,   lockend_d;

  // Working signals
  logic                 has_ao, has_do;
  logic [SW-1:0]        sample;
  logic [EW-1:0]        edges;
  logic                 level;
  logic [EW:0]          sum;
  logic [EW-1:0]        tot1;
  logic [SW-1:0]        peak1;
  logic [TIME_BITS-1:0] win_el, chk_el, q_el, lock_d, cool;
  logic                 close, qual, hit;
  logic                 locked_old, locked_new, chk_due, quiet, chk;

  always_comb begin
    has_ao = cfg_i.sensor_mode[pimq_pkg::MODE_ANALOG_BIT];
    has_do = cfg_i.sensor_mode[pimq_pkg::MODE_DIGITAL_BIT];
    sample = has_ao ? item_i.analog_sample : '0;
    edges  = has_do ? item_i.edge_count : '0;
    level  = has_do & item_i.comparator_level;

    // window accumulation, saturating edge total
    sum   = {1'b0, total_q} + {1'b0, edges};
    tot1  = sum[EW] ? pimq_pkg::EDGE_MAX : sum[EW-1:0];
    peak1 = (sample > peak_q) ? sample : peak_q;

    // lockout test at this tick, before any new hit
    lock_d     = lockend_q - time_i;
    locked_old = (lock_d != '0) && !lock_d[TIME_BITS-1];

    // window close and hit decision
    win_el = time_i - start_q;
    close  = open_q && (win_el >= TIME_BITS'(cfg_i.window_ms));
    qual   = (by_edges_q && (tot1 >= cfg_i.min_edges)) ||
             (has_ao && (peak1 >= cfg_i.hit_thr));
    hit    = close && qual && !item_i.blocked && !locked_old;

    // a hit sets lockout_end to now + cooldown, so the difference is cooldown
    cool       = TIME_BITS'(cfg_i.lockout_ms);
    locked_new = hit ? ((cool != '0) && !cool[TIME_BITS-1]) : locked_old;

    open_d     = open_q && !close;
    start_d    = start_q;
    peak_d     = open_q ? peak1 : peak_q;
    total_d    = open_q ? tot1 : total_q;
    by_edges_d = open_q ? (by_edges_q && !close) : by_edges_q;
    armed_d    = armed_q && !hit;
    qvalid_d   = qvalid_q && !hit;
    qsince_d   = qsince_q;
    lastchk_d  = hit ? time_i : lastchk_q;
    lockend_d  = hit ? (time_i + cool) : lockend_q;

    // periodic quiet check while disarmed
    chk_el  = time_i - lastchk_q;
    chk_due = hit ? (cfg_i.rearm_check_ms == '0)
                  : (chk_el >= TIME_BITS'(cfg_i.rearm_check_ms));
    chk     = !armed_d && !locked_new && chk_due;
    if (has_ao) begin
      quiet = sample < cfg_i.rearm_thr;
    end else if (has_do) begin
      quiet = !level;
    end else begin
      quiet = 1'b1;
    end
    q_el = time_i - qsince_q;
    if (chk) begin
      lastchk_d = time_i;
      if (!quiet) begin
        qvalid_d = 1'b0;
      end else if (!qvalid_d) begin
        qvalid_d = 1'b1;
        qsince_d = time_i;
      end else if (q_el >= TIME_BITS'(cfg_i.quiet_hold_ms)) begin
        armed_d  = 1'b1;
        qvalid_d = 1'b0;
      end
    end

    // open a new window
    if (!item_i.blocked && !open_d && armed_d && !locked_new &&
        ((edges != '0) || (has_ao && (sample >= cfg_i.hit_thr)))) begin
      open_d     = 1'b1;
      start_d    = time_i;
      peak_d     = sample;
      total_d    = edges;
      by_edges_d = (edges != '0);
    end

    // result; an empty peak without analog sensor reports the threshold
    res_o.hit        = hit;
    res_o.hit_peak   = hit ? (((peak1 == '0) && !has_ao) ? cfg_i.hit_thr : peak1) : '0;
    res_o.hit_edges  = hit ? tot1 : '0;
    res_o.is_armed   = armed_d;
    res_o.capturing  = open_d;
    res_o.locked_out = locked_new;
  end

  // state update once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      start_q    <= '0;
      peak_q     <= '0;
      total_q    <= '0;
      by_edges_q <= 1'b0;
      armed_q    <= 1'b1;
      qvalid_q   <= 1'b0;
      qsince_q   <= '0;
      lastchk_q  <= '0;
      lockend_q  <= '0;
    end else if (en_i) begin
      open_q     <= open_d;
      start_q    <= start_d;
      peak_q     <= peak_d;
      total_q    <= total_d;
      by_edges_q <= by_edges_d;
      armed_q    <= armed_d;
      qvalid_q   <= qvalid_d;
      qsince_q   <= qsince_d;
      lastchk_q  <= lastchk_d;
      lockend_q  <= lockend_d;
    end
  end

endmodule

>>> rtl/piezo_impact_qualifier_unit.sv
// Top level of the piezo impact qualifier: stream channels, input and result
// registers, configuration port. Depends on pimq_pkg, pimq_cfg, pimq_core.
//
// Usage:
//   One input item is one sample tick on the slave stream (s_axis_*): time,
//   analog sample, edge count and comparator level in tdata, the blocked
//   flag in tuser. Every tick yields exactly one result item on the master
//   stream (m_axis_*): hit flag in tuser, peak, edges and status in tdata.
//   An accepted item is held in the input register, evaluated against the
//   qualifier state, and its result is captured in the result register.
//   Throughput: one item per cycle unless stalled; the whole decision is one
//   pass of compare and add logic between the input register and the result
//   register, with the qualifier state updated as the item moves on.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item; then s_axis_tready drops until the
//   result is taken. Nothing is dropped or repeated.
//   Reset (rst_ni low) empties both registers, loads the default register
//   values and returns the qualifier to armed and idle, lockout end at zero.
//   Registers are written over the APB-style port at byte address 4*index,
//   which the user must do only while no item is in flight (not enforced).
module piezo_impact_qualifier_unit #(
  parameter int unsigned TIME_BITS = pimq_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: time_ms, analog_sample, edge_count, comparator_level, zero pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((TIME_BITS + pimq_pkg::SAMPLE_W + pimq_pkg::EDGE_W + 1 + 7) / 8) * 8 - 1:0]
                                          s_axis_tdata,
  // tuser: blocked
  input  logic [0:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: hit_peak, hit_edges, is_armed, capturing, locked_out, zero pad
  output logic [((pimq_pkg::SAMPLE_W + pimq_pkg::EDGE_W + 3 + 7) / 8) * 8 - 1:0]
                                          m_axis_tdata,
  // tuser: hit
  output logic [0:0]                      m_axis_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pimq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pimq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pimq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned SW    = pimq_pkg::SAMPLE_W;
  localparam int unsigned EW    = pimq_pkg::EDGE_W;
  localparam int unsigned OUT_W = SW + EW + 3;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  pimq_pkg::cfg_t      cfg;
  pimq_pkg::in_item_t  item_in, item_q;
  pimq_pkg::res_item_t res, res_q;
  logic [TIME_BITS-1:0] time_q;
  logic                 in_valid_q, in_valid_d;
  logic                 out_valid_q, out_valid_d;
  logic                 adv, s_acc;

  pimq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // unpack the incoming item
  assign item_in.analog_sample    = s_axis_tdata[TIME_BITS +: SW];
  assign item_in.edge_count       = s_axis_tdata[TIME_BITS + SW +: EW];
  assign item_in.comparator_level = s_axis_tdata[TIME_BITS + SW + EW];
  assign item_in.blocked          = s_axis_tuser[0];

  // handshake: the stage moves when the result register is free or drained
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_acc || (in_valid_q && !adv);
  assign out_valid_d   = adv || (out_valid_q && !m_axis_tready);

  pimq_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .cfg_i  (cfg),
    .time_i (time_q),
    .item_i (item_q),
    .res_o  (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      time_q <= s_axis_tdata[TIME_BITS-1:0];
      item_q <= item_in;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.hit;
  assign m_axis_tdata  = OUT_TDATA_W'({res_q.locked_out, res_q.capturing, res_q.is_armed,
                                       res_q.hit_edges, res_q.hit_peak});

endmodule

>>> sim/piezo_impact_qualifier_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for piezo_impact_qualifier_unit: streams sample ticks through the
// block, predicts every result item in step and checks it field by field.
// Depends on rtl/pimq_pkg.sv and rtl/piezo_impact_qualifier_unit.sv.
module piezo_impact_qualifier_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SW = pimq_pkg::SAMPLE_W;
  localparam int unsigned EW = pimq_pkg::EDGE_W;
  localparam int unsigned MW = pimq_pkg::MS_W;

  typedef enum {TK_QUIET, TK_STRIKE, TK_NOISE} tick_kind_e;

  // One sample tick as the sender sees it
  typedef struct {
    bit [31:0]   time_ms;
    bit [SW-1:0] sample;
    bit [EW-1:0] edges;
    bit          level;
    bit          blocked;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [pimq_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pimq_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pimq_pkg::CFG_DATA_W-1:0] prdata;
  logic        pready;

  // Stimulus and checking bookkeeping
  tick_t               tick_q[$];
  pimq_pkg::res_item_t verdict_q[$];
  tick_t               cur_tick;
  int unsigned ticks_pushed = 0;
  int unsigned ticks_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned cyc_count = 0;
  bit [31:0]   clock_ms = '0;
  int unsigned step_scale = 1;

  // Predictor copy of the registers and qualifier state
  pimq_pkg::cfg_t    cfg_m;
  bit                cap_open, cap_by_edges, armed, quiet_ok;
  bit [31:0]         cap_start, quiet_from, check_at, lock_end;
  bit [SW-1:0]       cap_peak;
  bit [EW-1:0]       cap_edges;

  piezo_impact_qualifier_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Wrap-safe elapsed time
  function automatic bit [31:0] elapsed_ms(input bit [31:0] now, input bit [31:0] since);
    return now - since;
  endfunction

  // Cooldown runs while the end lies strictly ahead, signed
  function automatic bit cooling(input bit [31:0] now);
    bit [31:0] d;
    d = lock_end - now;
    return (d != 0) && !d[31];
  endfunction

  // Qualifier state update for one tick; returns the result item it causes
  function automatic pimq_pkg::res_item_t qualify_tick(input tick_t t);
    pimq_pkg::res_item_t r;
    bit                has_ao, has_do, level, qual, quiet;
    bit [SW-1:0]       smp, pk;
    bit [EW-1:0]       edg, ed;
    bit [EW:0]         sum;
    bit [31:0]         now;
    has_ao = cfg_m.sensor_mode[pimq_pkg::MODE_ANALOG_BIT];
    has_do = cfg_m.sensor_mode[pimq_pkg::MODE_DIGITAL_BIT];
    now    = t.time_ms;
    smp    = has_ao ? t.sample : '0;
    edg    = has_do ? t.edges : '0;
    level  = has_do && t.level;
    r      = '0;

    // edges add up while the window is open, saturating
    if (cap_open && edg != 0) begin
      sum = {1'b0, cap_edges} + {1'b0, edg};
      cap_edges = sum[EW] ? pimq_pkg::EDGE_MAX : sum[EW-1:0];
    end

    // peak tracking and window close
    if (cap_open) begin
      if (smp > cap_peak) cap_peak = smp;
      if (elapsed_ms(now, cap_start) >= {16'h0, cfg_m.window_ms}) begin
        qual = cap_by_edges && (cap_edges >= cfg_m.min_edges);
        pk   = cap_peak;
        ed   = cap_edges;
        if (has_ao && pk >= cfg_m.hit_thr) qual = 1'b1;
        cap_open = 1'b0; cap_start = '0; cap_peak = '0;
        cap_edges = '0; cap_by_edges = 1'b0;
        if (qual && !t.blocked && !cooling(now)) begin
          if (pk == 0 && !has_ao) pk = cfg_m.hit_thr;
          r.hit       = 1'b1;
          r.hit_peak  = pk;
          r.hit_edges = ed;
          lock_end    = now + {16'h0, cfg_m.lockout_ms};
          armed       = 1'b0;
          quiet_ok    = 1'b0;
          quiet_from  = '0;
          check_at    = now;
        end
      end
    end

    // periodic quiet checks while disarmed
    if (!armed && !cooling(now) &&
        elapsed_ms(now, check_at) >= {16'h0, cfg_m.rearm_check_ms}) begin
      check_at = now;
      if (has_ao) quiet = smp < cfg_m.rearm_thr;
      else if (has_do) quiet = !level;
      else quiet = 1'b1;
      if (!quiet) begin
        quiet_ok = 1'b0;
        quiet_from = '0;
      end else if (!quiet_ok) begin
        quiet_ok = 1'b1;
        quiet_from = now;
      end else if (elapsed_ms(now, quiet_from) >= {16'h0, cfg_m.quiet_hold_ms}) begin
        armed = 1'b1;
        quiet_ok = 1'b0;
        quiet_from = '0;
      end
    end

    // new capture window
    if (!t.blocked && !cap_open && armed && !cooling(now)) begin
      if (edg != 0 || (has_ao && smp >= cfg_m.hit_thr)) begin
        cap_open     = 1'b1;
        cap_start    = now;
        cap_peak     = smp;
        cap_edges    = edg;
        cap_by_edges = edg != 0;
      end
    end

    r.is_armed   = armed;
    r.capturing  = cap_open;
    r.locked_out = cooling(now);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    err_count++;
    $display("[%0t] result %0d: %s expected 0x%0h got 0x%0h",
             $realtime, results_seen, what, want_v, got_v);
  endtask

  task automatic push_tick(input bit [31:0] tm, input bit [SW-1:0] smp,
                           input bit [EW-1:0] edg, input bit lvl, input bit blk);
    tick_t t;
    t.time_ms = tm; t.sample = smp; t.edges = edg; t.level = lvl; t.blocked = blk;
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  // Mostly short steps, sometimes long ones, rarely an arbitrary jump
  function automatic bit [31:0] next_step();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 3);
    else if (r < 85) return $urandom_range(4, 40) * step_scale;
    else if (r < 97) return $urandom_range(41, 400) * step_scale;
    return $urandom;
  endfunction

  task automatic push_random(input tick_kind_e kind);
    tick_t t;
    if (kind != TK_NOISE) clock_ms += next_step();
    t.time_ms = clock_ms;
    case (kind)
      TK_STRIKE: begin
        t.sample  = SW'($urandom_range(0, 4095));
        t.edges   = ($urandom_range(0, 9) == 0) ? EW'($urandom_range(0, 65535))
                                                 : EW'($urandom_range(0, 4));
        t.level   = 1'($urandom_range(0, 1));
        t.blocked = $urandom_range(0, 9) == 0;
      end
      TK_QUIET: begin
        t.sample  = SW'($urandom_range(0, 800));
        t.edges   = ($urandom_range(0, 19) == 0) ? EW'(1) : EW'(0);
        t.level   = $urandom_range(0, 9) == 0;
        t.blocked = $urandom_range(0, 19) == 0;
      end
      default: begin
        // noise: anything, time too, without moving the running clock
        t.time_ms = $urandom;
        t.sample  = SW'($urandom);
        t.edges   = EW'($urandom);
        t.level   = 1'($urandom_range(0, 1));
        t.blocked = 1'($urandom_range(0, 1));
      end
    endcase
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  // Strikes followed by quiet stretches, with some noise mixed in
  task automatic random_phase(input int unsigned n);
    int unsigned made, len, i;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_random(TK_NOISE);
        made++;
      end else begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) push_random(TK_STRIKE);
        made += len;
        len = $urandom_range(2, 15);
        for (i = 0; i < len; i++) push_random(TK_QUIET);
        made += len;
      end
    end
  endtask

  task automatic wait_idle();
    while (!(ticks_accepted == ticks_pushed && verdict_q.size() == 0)) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup then access; the register takes the value at the access edge
  task automatic write_reg(input pimq_pkg::reg_idx_e idx, input bit [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pimq_pkg::REG_HIT_THR:     cfg_m.hit_thr        = value[SW-1:0];
      pimq_pkg::REG_REARM_THR:   cfg_m.rearm_thr      = value[SW-1:0];
      pimq_pkg::REG_WINDOW:      cfg_m.window_ms      = value[MW-1:0];
      pimq_pkg::REG_MIN_EDGES:   cfg_m.min_edges      = value[EW-1:0];
      pimq_pkg::REG_COOLDOWN:    cfg_m.lockout_ms     = value[MW-1:0];
      pimq_pkg::REG_REARM_CHECK: cfg_m.rearm_check_ms = value[MW-1:0];
      pimq_pkg::REG_REARM_STAB:  cfg_m.quiet_hold_ms  = value[MW-1:0];
      pimq_pkg::REG_MODE:        cfg_m.sensor_mode    = value[pimq_pkg::MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input bit [11:0] hit_thr, input bit [11:0] rearm_thr,
                               input bit [15:0] win, input bit [15:0] min_e,
                               input bit [15:0] cool, input bit [15:0] chk,
                               input bit [15:0] stab, input bit [1:0] mode);
    write_reg(pimq_pkg::REG_HIT_THR, 32'(hit_thr));
    write_reg(pimq_pkg::REG_REARM_THR, 32'(rearm_thr));
    write_reg(pimq_pkg::REG_WINDOW, 32'(win));
    write_reg(pimq_pkg::REG_MIN_EDGES, 32'(min_e));
    write_reg(pimq_pkg::REG_COOLDOWN, 32'(cool));
    write_reg(pimq_pkg::REG_REARM_CHECK, 32'(chk));
    write_reg(pimq_pkg::REG_REARM_STAB, 32'(stab));
    write_reg(pimq_pkg::REG_MODE, 32'(mode));
  endtask

  // Main sequence: reset, directed ticks, then phases of random ticks
  initial begin
    int unsigned ph;
    cfg_m = '{hit_thr: pimq_pkg::HIT_THR_RST, rearm_thr: pimq_pkg::REARM_THR_RST,
              window_ms: pimq_pkg::WINDOW_RST, min_edges: pimq_pkg::MIN_EDGES_RST,
              lockout_ms: pimq_pkg::COOLDOWN_RST,
              rearm_check_ms: pimq_pkg::REARM_CHECK_RST,
              quiet_hold_ms: pimq_pkg::REARM_STAB_RST,
              sensor_mode: pimq_pkg::MODE_RST};
    cap_open = 1'b0; cap_by_edges = 1'b0; armed = 1'b1; quiet_ok = 1'b0;
    cap_start = '0; quiet_from = '0; check_at = '0; lock_end = '0;
    cap_peak = '0; cap_edges = '0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;

    // directed: full-scale strike, saturating edges, lockout, re-arm,
    // edge-started hit, blocked capture, wrap of the time counter
    push_tick(32'd0,   12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd1,   12'hFFF,  16'd0,     1'b0, 1'b0);
    push_tick(32'd2,   12'd10,   16'hFFFF,  1'b1, 1'b0);
    push_tick(32'd3,   12'd0,    16'hFFFF,  1'b1, 1'b0);
    push_tick(32'd21,  12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd30,  12'hFFF,  16'd5,     1'b1, 1'b0);
    push_tick(32'd272, 12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd282, 12'd100,  16'd0,     1'b0, 1'b0);
    push_tick(32'd352, 12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd360, 12'd100,  16'd1,     1'b1, 1'b0);
    push_tick(32'd380, 12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd700, 12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd710, 12'd3000, 16'd0,     1'b1, 1'b0);
    push_tick(32'd720, 12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd800, 12'd0,    16'd0,     1'b0, 1'b0);
    push_tick(32'd801, 12'd2000, 16'd0,     1'b0, 1'b1);
    push_tick(32'd802, 12'd2000, 16'd0,     1'b0, 1'b0);
    push_tick(32'd822, 12'd0,    16'd0,     1'b0, 1'b1);
    push_tick(32'hFFFF_FFF0, 12'd1500, 16'd0, 1'b0, 1'b0);
    push_tick(32'h0000_0300, 12'hAAA,  16'h5555, 1'b1, 1'b0);
    push_tick(32'h0000_0314, 12'h555,  16'hAAAA, 1'b0, 1'b0);
    push_tick(32'h0000_0315, 12'hFFF,  16'd0, 1'b0, 1'b0);
    wait_idle();

    // defaults written back, clock close to wrapping
    load_settings(12'd1200, 12'd400, 16'd20, 16'd1, 16'd250, 16'd10, 16'd80, 2'd3);
    clock_ms = 32'hFFFF_FF00;
    random_phase(70);
    wait_idle();

    // low extremes: analog only, zero window, no cooldown
    load_settings(12'hFFF, 12'h000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 2'd1);
    random_phase(70);
    wait_idle();

    // high extremes: comparator only, long times need long steps
    load_settings(12'h000, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2);
    step_scale = 300;
    random_phase(70);
    wait_idle();

    // random settings across every sensor mode
    step_scale = 1;
    for (ph = 0; ph < 4; ph++) begin
      load_settings(12'($urandom_range(300, 3500)), 12'($urandom_range(0, 1500)),
                    16'($urandom_range(0, 40)), 16'($urandom_range(0, 6)),
                    16'($urandom_range(0, 300)), 16'($urandom_range(0, 30)),
                    16'($urandom_range(0, 120)), ph[1:0]);
      clock_ms = $urandom;
      random_phase(70);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sender: bursts of random length, random gaps between them
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin : tick_driver
    bit nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(qualify_tick(cur_tick));
        ticks_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (tick_q.size() > 0) begin
          cur_tick = tick_q.pop_front();
          s_axis_tdata <= {3'b000, cur_tick.level, cur_tick.edges, cur_tick.sample,
                           cur_tick.time_ms};
          s_axis_tuser <= cur_tick.blocked;
          nxt_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  // Receiver: stall pattern changes now and then; long hold-offs fill the block
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 50;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 120;

  always @(posedge clk) begin : ready_pattern
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (results_seen >= next_hold_at) begin
        hold_left = $urandom_range(40, 80);
        next_hold_at += 220;
      end
      if (rx_mode_left > 0) begin
        rx_mode_left--;
      end else begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(20, 100);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : result_monitor
    pimq_pkg::res_item_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit        = m_axis_tuser[0];
      got.hit_peak   = m_axis_tdata[11:0];
      got.hit_edges  = m_axis_tdata[27:12];
      got.is_armed   = m_axis_tdata[28];
      got.capturing  = m_axis_tdata[29];
      got.locked_out = m_axis_tdata[30];
      results_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("item with none pending, hit", 0, 32'(got.hit));
      end else begin
        want = verdict_q.pop_front();
        if (got.hit !== want.hit)
          report_mismatch("hit", 32'(want.hit), 32'(got.hit));
        if (got.hit_peak !== want.hit_peak)
          report_mismatch("hit_peak", 32'(want.hit_peak), 32'(got.hit_peak));
        if (got.hit_edges !== want.hit_edges)
          report_mismatch("hit_edges", 32'(want.hit_edges), 32'(got.hit_edges));
        if (got.is_armed !== want.is_armed)
          report_mismatch("is_armed", 32'(want.is_armed), 32'(got.is_armed));
        if (got.capturing !== want.capturing)
          report_mismatch("capturing", 32'(want.capturing), 32'(got.capturing));
        if (got.locked_out !== want.locked_out)
          report_mismatch("locked_out", 32'(want.locked_out), 32'(got.locked_out));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
